>>> rtl/pws_pkg.sv
// Shared types and constants for the perspective warp sampler.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package pws_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int COEF_W     = 32;
  localparam int SIZE_W     = 13;
  localparam int MODE_W     = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_AFFINE_ROW0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AFFINE_ROW1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PERSP_PAIR  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_MODE = 3'd7;

  // sample_mode bits
  localparam int MODE_BILINEAR = 0;
  localparam int MODE_WIDE     = 1;

  // token travelling with each transaction down the pipe
  typedef struct packed {
    logic valid;
    logic ok;     // w > 0, both numerators non-negative, quotients below 2^COORD_BITS
  } pws_tok_t;

endpackage

`default_nettype wire

>>> rtl/pws_front.sv
// Front end: coefficient products, projective sums and range pre-checks.
// Depends on pws_pkg. Three register stages feeding the divider chain.
`timescale 1ns / 1ps
`default_nettype none

module pws_front #(
  parameter int C  = 12,
  parameter int F  = 8,
  parameter int DW = C + 34,
  parameter int RW = DW + 1,
  parameter int QB = C + F
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  output logic                                rdy_o,
  input  logic [C-1:0]                        x_i,
  input  logic [C-1:0]                        y_i,
  input  logic signed [pws_pkg::COEF_W-1:0]   a00_i,
  input  logic signed [pws_pkg::COEF_W-1:0]   a01_i,
  input  logic signed [pws_pkg::COEF_W-1:0]   a10_i,
  input  logic signed [pws_pkg::COEF_W-1:0]   a11_i,
  input  logic signed [pws_pkg::COEF_W-1:0]   offx_i,
  input  logic signed [pws_pkg::COEF_W-1:0]   offy_i,
  input  logic signed [pws_pkg::COEF_W-1:0]   p0_i,
  input  logic signed [pws_pkg::COEF_W-1:0]   p1_i,
  input  logic                                rdy_i,
  output pws_pkg::pws_tok_t                   tok_o,
  output logic [DW-1:0]                       den_o,
  output logic [RW-1:0]                       rx_o,
  output logic [RW-1:0]                       ry_o,
  output logic [QB-1:0]                       lx_o,
  output logic [QB-1:0]                       ly_o
);
  import pws_pkg::*;

  localparam int PW = C + 33;
  localparam int UW = C + 36;
  localparam int TW = UW + C + 11;
  localparam int NW = UW + 10 + F;
  localparam logic signed [UW-1:0] W_ONE = {{(UW-31){1'b0}}, 1'b1, 30'b0};

  // stage A: products
  logic                 va_q;
  logic signed [PW-1:0] m00_q, m01_q, m10_q, m11_q, mp0_q, mp1_q;
  logic signed [COEF_W-1:0] offx_q, offy_q;
  // stage B: sums
  logic                 vb_q;
  logic signed [UW-1:0] u_q, v_q, w_q;
  // stage C: pre-checks and divider seed
  logic                 vc_q;
  logic                 okc_q;
  logic [DW-1:0]        den_q;
  logic [RW-1:0]        rx_q, ry_q;
  logic [QB-1:0]        lx_q, ly_q;

  logic rdy_a, rdy_b, rdy_c;
  logic signed [C:0] xs, ys;
  logic signed [UW-1:0] u_d, v_d, w_d;
  logic [TW-1:0] ut, vt, wt;
  logic [NW-1:0] nx, ny;
  logic ok_d;

  assign rdy_c = !vc_q || rdy_i;
  assign rdy_b = !vb_q || rdy_c;
  assign rdy_a = !va_q || rdy_b;
  assign rdy_o = rdy_a;

  assign xs = signed'({1'b0, x_i});
  assign ys = signed'({1'b0, y_i});

  assign u_d = UW'(m00_q) + UW'(m01_q) + (UW'(offx_q) <<< 8);
  assign v_d = UW'(m10_q) + UW'(m11_q) + (UW'(offy_q) <<< 8);
  assign w_d = UW'(mp0_q) + UW'(mp1_q) + W_ONE;

  // quotient must stay below 2^C, i.e. u*2^10 < w*2^C
  assign ut = TW'(unsigned'(u_q)) << 10;
  assign vt = TW'(unsigned'(v_q)) << 10;
  assign wt = TW'(unsigned'(w_q)) << C;
  assign ok_d = !w_q[UW-1] && (w_q != '0) && !u_q[UW-1] && !v_q[UW-1]
                && (ut < wt) && (vt < wt);

  assign nx = NW'(unsigned'(u_q)) << (10 + F);
  assign ny = NW'(unsigned'(v_q)) << (10 + F);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (rdy_a) va_q <= valid_i;
      if (rdy_b) vb_q <= va_q;
      if (rdy_c) vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a && valid_i) begin
      m00_q  <= a00_i * xs;
      m01_q  <= a01_i * ys;
      m10_q  <= a10_i * xs;
      m11_q  <= a11_i * ys;
      mp0_q  <= p0_i * xs;
      mp1_q  <= p1_i * ys;
      offx_q <= offx_i;
      offy_q <= offy_i;
    end
    if (rdy_b && va_q) begin
      u_q <= u_d;
      v_q <= v_d;
      w_q <= w_d;
    end
    if (rdy_c && vb_q) begin
      okc_q <= ok_d;
      den_q <= DW'(unsigned'(w_q));
      rx_q  <= RW'(nx >> QB);
      ry_q  <= RW'(ny >> QB);
      lx_q  <= nx[QB-1:0];
      ly_q  <= ny[QB-1:0];
    end
  end

  assign tok_o = '{valid: vc_q, ok: okc_q};
  assign den_o = den_q;
  assign rx_o  = rx_q;
  assign ry_o  = ry_q;
  assign lx_o  = lx_q;
  assign ly_o  = ly_q;

endmodule

`default_nettype wire

>>> rtl/pws_div_cell.sv
// One cell of the divider chain: one restoring quotient bit for both axes.
// Depends on pws_pkg. Cells are chained, one per quotient bit.
`timescale 1ns / 1ps
`default_nettype none

module pws_div_cell #(
  parameter int DW = 46,
  parameter int RW = DW + 1,
  parameter int QB = 20
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pws_pkg::pws_tok_t tok_i,
  output logic              rdy_o,
  input  logic [DW-1:0]     den_i,
  input  logic [RW-1:0]     rx_i,
  input  logic [RW-1:0]     ry_i,
  input  logic [QB-1:0]     lx_i,
  input  logic [QB-1:0]     ly_i,
  input  logic [QB-1:0]     qx_i,
  input  logic [QB-1:0]     qy_i,
  input  logic              rdy_i,
  output pws_pkg::pws_tok_t tok_o,
  output logic [DW-1:0]     den_o,
  output logic [RW-1:0]     rx_o,
  output logic [RW-1:0]     ry_o,
  output logic [QB-1:0]     lx_o,
  output logic [QB-1:0]     ly_o,
  output logic [QB-1:0]     qx_o,
  output logic [QB-1:0]     qy_o
);
  import pws_pkg::*;

  logic          v_q, ok_q;
  logic [DW-1:0] den_q;
  logic [RW-1:0] rx_q, ry_q, rx_d, ry_d;
  logic [QB-1:0] lx_q, ly_q, qx_q, qy_q, qx_d, qy_d;

  // shift in the next numerator bit, subtract the divisor if it fits
  function automatic logic [RW:0] div_step(input logic [RW-1:0] r, input logic nb,
                                           input logic [DW-1:0] d);
    logic [RW-1:0] t;
    logic          ge;
    t  = {r[RW-2:0], nb};
    ge = (t >= {1'b0, d});
    return {ge, ge ? (t - {1'b0, d}) : t};
  endfunction

  assign rdy_o = !v_q || rdy_i;

  always_comb begin
    logic [RW:0] sx, sy;
    sx   = div_step(rx_i, lx_i[QB-1], den_i);
    sy   = div_step(ry_i, ly_i[QB-1], den_i);
    rx_d = sx[RW-1:0];
    ry_d = sy[RW-1:0];
    qx_d = {qx_i[QB-2:0], sx[RW]};
    qy_d = {qy_i[QB-2:0], sy[RW]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (rdy_o) begin
      v_q <= tok_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_o && tok_i.valid) begin
      ok_q  <= tok_i.ok;
      den_q <= den_i;
      rx_q  <= rx_d;
      ry_q  <= ry_d;
      lx_q  <= {lx_i[QB-2:0], 1'b0};
      ly_q  <= {ly_i[QB-2:0], 1'b0};
      qx_q  <= qx_d;
      qy_q  <= qy_d;
    end
  end

  assign tok_o = '{valid: v_q, ok: ok_q};
  assign den_o = den_q;
  assign rx_o  = rx_q;
  assign ry_o  = ry_q;
  assign lx_o  = lx_q;
  assign ly_o  = ly_q;
  assign qx_o  = qx_q;
  assign qy_o  = qy_q;

endmodule

`default_nettype wire

>>> rtl/pws_back.sv
// Back end: bound test, rounding or fraction split, and the output register.
// Depends on pws_pkg; fed by the last divider cell.
`timescale 1ns / 1ps
`default_nettype none

module pws_back #(
  parameter int C  = 12,
  parameter int F  = 8,
  parameter int QB = C + F
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  pws_pkg::pws_tok_t                 tok_i,
  output logic                              rdy_o,
  input  logic [QB-1:0]                     qx_i,
  input  logic [QB-1:0]                     qy_i,
  input  logic [pws_pkg::SIZE_W-1:0]        width_i,
  input  logic [pws_pkg::SIZE_W-1:0]        height_i,
  input  logic [pws_pkg::MODE_W-1:0]        mode_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              inside_o,
  output logic [C-1:0]                      src_x_o,
  output logic [C-1:0]                      src_y_o,
  output logic [F-1:0]                      frac_x_o,
  output logic [F-1:0]                      frac_y_o
);
  import pws_pkg::*;

  localparam int SXW = (SIZE_W > C + 1) ? SIZE_W : C + 1;
  localparam logic [C:0] LIM = {1'b1, {C{1'b0}}};

  logic          v_q, in_q;
  logic [C-1:0]  sx_q, sy_q;
  logic [F-1:0]  fx_q, fy_q;
  logic [C+F:0]  ax, ay;
  logic          in_d;

  // returns {inside, coord, frac} for one axis
  function automatic logic [C+F:0] map_axis(input logic [QB-1:0] q,
                                            input logic [SIZE_W-1:0] size,
                                            input logic [MODE_W-1:0] mode);
    logic [C:0]   sz, bound, qi, qr, top;
    logic [F-1:0] fr;
    logic         in;
    sz    = (SXW'(size) > SXW'(LIM)) ? LIM : (C+1)'(size);
    bound = mode[MODE_WIDE] ? sz : ((sz != '0) ? sz - 1'b1 : '0);
    qi    = {1'b0, q[QB-1:F]};
    fr    = q[F-1:0];
    in    = (qi < bound);
    top   = sz - 1'b1;
    qr    = qi + (C+1)'(fr[F-1]);   // half rounds up
    if (qr > top) qr = top;
    if (mode[MODE_BILINEAR]) begin
      return {in, qi[C-1:0], fr};
    end else begin
      return {in, qr[C-1:0], {F{1'b0}}};
    end
  endfunction

  assign ax   = map_axis(qx_i, width_i, mode_i);
  assign ay   = map_axis(qy_i, height_i, mode_i);
  assign in_d = tok_i.ok && ax[C+F] && ay[C+F];

  assign rdy_o = !v_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (rdy_o) begin
      v_q <= tok_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_o && tok_i.valid) begin
      in_q <= in_d;
      sx_q <= in_d ? ax[C+F-1:F] : '0;
      sy_q <= in_d ? ay[C+F-1:F] : '0;
      fx_q <= in_d ? ax[F-1:0] : '0;
      fy_q <= in_d ? ay[F-1:0] : '0;
    end
  end

  assign out_valid_o = v_q;
  assign inside_o    = in_q;
  assign src_x_o     = sx_q;
  assign src_y_o     = sy_q;
  assign frac_x_o    = fx_q;
  assign frac_y_o    = fy_q;

endmodule

`default_nettype wire

>>> rtl/perspective_warp_sampler_unit.sv
// Top level of the perspective warp sampler: configuration registers and pipeline.
// Depends on pws_pkg, pws_front, pws_div_cell and pws_back.
`timescale 1ns / 1ps
`default_nettype none

// Maps each output pixel through the programmed inverse homography and returns
// the source position, inside flag and bilinear weights. One coordinate pair is
// taken every clock unless in_stall_o is raised. The pipe holds three front
// stages (products, sums and range checks), one divider cell per quotient bit
// and one output register. Stall ripples back stage by stage, so bubbles in
// the pipe keep absorbing input while the output is held. Registers
// must only be written while no transaction is in flight.
module perspective_warp_sampler_unit #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [pws_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [pws_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [COORD_BITS-1:0]             out_x_i,
  input  logic [COORD_BITS-1:0]             out_y_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              inside_res_o,
  output logic [COORD_BITS-1:0]             src_x_o,
  output logic [COORD_BITS-1:0]             src_y_o,
  output logic [FRAC_BITS-1:0]              frac_x_o,
  output logic [FRAC_BITS-1:0]              frac_y_o
);
  import pws_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int QB = C + F;
  localparam int DW = C + 34;
  localparam int RW = DW + 1;

  logic [63:0]        row0_q, row1_q, persp_q;
  logic [COEF_W-1:0]  offx_q, offy_q;
  logic [SIZE_W-1:0]  width_q, height_q;
  logic [MODE_W-1:0]  mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row0_q   <= 64'd1048576;
      offx_q   <= '0;
      row1_q   <= 64'd4503599627370496;
      offy_q   <= '0;
      persp_q  <= '0;
      width_q  <= 13'd4096;
      height_q <= 13'd4096;
      mode_q   <= 2'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_AFFINE_ROW0: row0_q   <= cfg_data_i;
        REG_OFFSET_X:    offx_q   <= cfg_data_i[COEF_W-1:0];
        REG_AFFINE_ROW1: row1_q   <= cfg_data_i;
        REG_OFFSET_Y:    offy_q   <= cfg_data_i[COEF_W-1:0];
        REG_PERSP_PAIR:  persp_q  <= cfg_data_i;
        REG_SRC_WIDTH:   width_q  <= cfg_data_i[SIZE_W-1:0];
        REG_SRC_HEIGHT:  height_q <= cfg_data_i[SIZE_W-1:0];
        REG_SAMPLE_MODE: mode_q   <= cfg_data_i[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  pws_tok_t       tok_w [QB+1];
  logic           rdy_w [QB+1];
  logic [DW-1:0]  den_w [QB+1];
  logic [RW-1:0]  rx_w  [QB+1];
  logic [RW-1:0]  ry_w  [QB+1];
  logic [QB-1:0]  lx_w  [QB+1];
  logic [QB-1:0]  ly_w  [QB+1];
  logic [QB-1:0]  qx_w  [QB+1];
  logic [QB-1:0]  qy_w  [QB+1];
  logic           front_rdy;

  assign in_stall_o = !front_rdy;
  assign qx_w[0] = '0;
  assign qy_w[0] = '0;

  pws_front #(.C(C), .F(F), .DW(DW), .RW(RW), .QB(QB)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .rdy_o   (front_rdy),
    .x_i     (out_x_i),
    .y_i     (out_y_i),
    .a00_i   (signed'(row0_q[31:0])),
    .a01_i   (signed'(row0_q[63:32])),
    .a10_i   (signed'(row1_q[31:0])),
    .a11_i   (signed'(row1_q[63:32])),
    .offx_i  (signed'(offx_q)),
    .offy_i  (signed'(offy_q)),
    .p0_i    (signed'(persp_q[31:0])),
    .p1_i    (signed'(persp_q[63:32])),
    .rdy_i   (rdy_w[0]),
    .tok_o   (tok_w[0]),
    .den_o   (den_w[0]),
    .rx_o    (rx_w[0]),
    .ry_o    (ry_w[0]),
    .lx_o    (lx_w[0]),
    .ly_o    (ly_w[0])
  );

  for (genvar i = 0; i < QB; i++) begin : g_cell
    pws_div_cell #(.DW(DW), .RW(RW), .QB(QB)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tok_i  (tok_w[i]),
      .rdy_o  (rdy_w[i]),
      .den_i  (den_w[i]),
      .rx_i   (rx_w[i]),
      .ry_i   (ry_w[i]),
      .lx_i   (lx_w[i]),
      .ly_i   (ly_w[i]),
      .qx_i   (qx_w[i]),
      .qy_i   (qy_w[i]),
      .rdy_i  (rdy_w[i+1]),
      .tok_o  (tok_w[i+1]),
      .den_o  (den_w[i+1]),
      .rx_o   (rx_w[i+1]),
      .ry_o   (ry_w[i+1]),
      .lx_o   (lx_w[i+1]),
      .ly_o   (ly_w[i+1]),
      .qx_o   (qx_w[i+1]),
      .qy_o   (qy_w[i+1])
    );
  end

  pws_back #(.C(C), .F(F), .QB(QB)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_i       (tok_w[QB]),
    .rdy_o       (rdy_w[QB]),
    .qx_i        (qx_w[QB]),
    .qy_i        (qy_w[QB]),
    .width_i     (width_q),
    .height_i    (height_q),
    .mode_i      (mode_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .inside_o    (inside_res_o),
    .src_x_o     (src_x_o),
    .src_y_o     (src_y_o),
    .frac_x_o    (frac_x_o),
    .frac_y_o    (frac_y_o)
  );

  // outside results carry no position
  a_outside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !inside_res_o |-> src_x_o == '0 && src_y_o == '0
                                     && frac_x_o == '0 && frac_y_o == '0)
    else $error("outside transaction with non-zero fields");

  a_nearest_frac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !mode_q[MODE_BILINEAR] |-> frac_x_o == '0 && frac_y_o == '0)
    else $error("nearest mode produced a fraction");

  a_inside_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && inside_res_o |-> 32'(src_x_o) < 32'(width_q)
                                    && 32'(src_y_o) < 32'(height_q))
    else $error("inside transaction beyond source size");

endmodule

`default_nettype wire

>>> test/testbench.sv
// Self-checking testbench for perspective_warp_sampler_unit: coordinate mapping
// through a programmed inverse homography, checked against an in-bench predictor.
// Depends on rtl/pws_pkg.sv and the sampler RTL.
`timescale 1ns / 1ps

module testbench;
  import pws_pkg::*;

  localparam int CB = 12;
  localparam int FB = 8;
  localparam int LATENCY = CB + FB + 4;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [CB-1:0] x;
    logic [CB-1:0] y;
  } pixel_t;

  typedef struct {
    logic          hit;
    logic [CB-1:0] sx;
    logic [CB-1:0] sy;
    logic [FB-1:0] fx;
    logic [FB-1:0] fy;
  } sample_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [CB-1:0]         out_x_i = '0;
  logic [CB-1:0]         out_y_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic                  inside_res_o;
  logic [CB-1:0]         src_x_o;
  logic [CB-1:0]         src_y_o;
  logic [FB-1:0]         frac_x_o;
  logic [FB-1:0]         frac_y_o;

  // mirror of the register file as the predictor sees it
  logic [63:0] warp_reg [8];

  pixel_t  pixel_q[$];
  sample_t sample_q[$];
  int      errors = 0;
  int      cycles = 0;
  bit      quiet_sender = 1'b0;

  perspective_warp_sampler_unit #(.COORD_BITS(CB), .FRAC_BITS(FB)) u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .out_x_i, .out_y_i,
    .out_valid_o, .out_stall_i, .inside_res_o,
    .src_x_o, .src_y_o, .frac_x_o, .frac_y_o
  );

  always #6 clk_i = ~clk_i;

  function automatic longint coef(input logic [31:0] bits);
    return longint'($signed(bits));
  endfunction

  // one axis: num in Q.20, den in Q.30 (den > 0)
  function automatic bit map_axis(input longint num, input longint unsigned den,
                                  input longint unsigned size, input bit wide,
                                  input bit bilin, output logic [CB-1:0] coord,
                                  output logic [FB-1:0] frac);
    longint unsigned bound, scaled, q, r;
    coord = '0;
    frac  = '0;
    if (size > (64'd1 << CB)) size = 64'd1 << CB;
    bound = wide ? size : (size > 0 ? size - 1 : 0);
    if (num < 0) return 1'b0;
    scaled = longint'(num) << 10;
    if (!(scaled < bound * den)) return 1'b0;
    q = scaled / den;
    r = scaled - q * den;
    if (bilin) begin
      longint unsigned fr;
      fr = (r << FB) / den;
      coord = q[CB-1:0];
      frac  = fr[FB-1:0];
    end else begin
      if (r >= den - r) q = q + 1;
      if (q > size - 1) q = size - 1;
      coord = q[CB-1:0];
    end
    return 1'b1;
  endfunction

  function automatic sample_t warp_pixel(input pixel_t p);
    sample_t s;
    longint  x, y, u, v, w;
    bit      ok;
    x = p.x;
    y = p.y;
    u = coef(warp_reg[REG_AFFINE_ROW0][31:0]) * x + coef(warp_reg[REG_AFFINE_ROW0][63:32]) * y
        + coef(warp_reg[REG_OFFSET_X][31:0]) * 256;
    v = coef(warp_reg[REG_AFFINE_ROW1][31:0]) * x + coef(warp_reg[REG_AFFINE_ROW1][63:32]) * y
        + coef(warp_reg[REG_OFFSET_Y][31:0]) * 256;
    w = coef(warp_reg[REG_PERSP_PAIR][31:0]) * x + coef(warp_reg[REG_PERSP_PAIR][63:32]) * y
        + (64'sd1 <<< 30);
    s = '{default: '0};
    ok = 1'b0;
    if (w > 0) begin
      ok = map_axis(u, w, warp_reg[REG_SRC_WIDTH][12:0], warp_reg[REG_SAMPLE_MODE][MODE_WIDE],
                    warp_reg[REG_SAMPLE_MODE][MODE_BILINEAR], s.sx, s.fx);
      if (ok)
        ok = map_axis(v, w, warp_reg[REG_SRC_HEIGHT][12:0],
                      warp_reg[REG_SAMPLE_MODE][MODE_WIDE],
                      warp_reg[REG_SAMPLE_MODE][MODE_BILINEAR], s.sy, s.fy);
    end
    if (!ok) s = '{default: '0};
    s.hit = ok;
    return s;
  endfunction

  // sender: bursts and gaps, payload held while stalled
  always @(posedge clk_i or negedge rst_ni) begin
    int burst_left, gap_left;
    pixel_t cur;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      burst_left = 1;
      gap_left = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        cur.x = out_x_i;
        cur.y = out_y_i;
        sample_q.push_back(warp_pixel(cur));
        void'(pixel_q.pop_front());
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pixel_q.size() > 0) begin
          in_valid_i <= 1'b1;
          out_x_i <= pixel_q[0].x;
          out_y_i <= pixel_q[0].y;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left = quiet_sender ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern switches between none, light and heavy
  always @(posedge clk_i or negedge rst_ni) begin
    int mode_left, stall_mode;
    sample_t e;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      mode_left = 0;
      stall_mode = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (sample_q.size() == 0) begin
          $error("result transaction with nothing expected");
          errors++;
        end else begin
          e = sample_q.pop_front();
          if (inside_res_o !== e.hit) begin
            $error("inside_res exp %0d got %0d", e.hit, inside_res_o); errors++;
          end
          if (src_x_o !== e.sx) begin
            $error("src_x exp %0d got %0d", e.sx, src_x_o); errors++;
          end
          if (src_y_o !== e.sy) begin
            $error("src_y exp %0d got %0d", e.sy, src_y_o); errors++;
          end
          if (frac_x_o !== e.fx) begin
            $error("frac_x exp %0d got %0d", e.fx, frac_x_o); errors++;
          end
          if (frac_y_o !== e.fy) begin
            $error("frac_y exp %0d got %0d", e.fy, frac_y_o); errors++;
          end
        end
      end
      if (mode_left == 0) begin
        mode_left = $urandom_range(64, 256);
        stall_mode = $urandom_range(0, 2);
      end
      mode_left--;
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 3) == 0);
        default: out_stall_i <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
    logic [63:0] m;
    case (idx)
      REG_OFFSET_X, REG_OFFSET_Y:  m = 64'hffff_ffff;
      REG_SRC_WIDTH, REG_SRC_HEIGHT: m = 64'h1fff;
      REG_SAMPLE_MODE:             m = 64'h3;
      default:                     m = '1;
    endcase
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    warp_reg[idx] = data & m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // every result in, then let the pipe settle
  task automatic wait_drained();
    while (pixel_q.size() > 0 || sample_q.size() > 0 || in_valid_i) @(posedge clk_i);
    repeat (LATENCY + 6) @(posedge clk_i);
  endtask

  task automatic add_pixel(input int x, input int y);
    pixel_t p;
    p.x = x;
    p.y = y;
    pixel_q.push_back(p);
  endtask

  function automatic logic [31:0] scaled_q20(input int lo, input int hi);
    return 32'($signed($urandom_range(0, hi - lo)) + lo);
  endfunction

  task automatic random_setup(input bit noise);
    int sz;
    if (noise) begin
      write_reg(REG_AFFINE_ROW0, {$urandom, $urandom});
      write_reg(REG_OFFSET_X, $urandom);
      write_reg(REG_AFFINE_ROW1, {$urandom, $urandom});
      write_reg(REG_OFFSET_Y, $urandom);
      write_reg(REG_PERSP_PAIR, {$urandom, $urandom});
    end else begin
      // plausible warps: scale 0..2, shear +-0.25, offsets +-1000 px, mild perspective
      write_reg(REG_AFFINE_ROW0, {scaled_q20(-(1 << 18), 1 << 18), scaled_q20(0, 2 << 20)});
      write_reg(REG_OFFSET_X, scaled_q20(-1000 * 4096, 1000 * 4096));
      write_reg(REG_AFFINE_ROW1, {scaled_q20(0, 2 << 20), scaled_q20(-(1 << 18), 1 << 18)});
      write_reg(REG_OFFSET_Y, scaled_q20(-1000 * 4096, 1000 * 4096));
      if ($urandom_range(0, 3) == 0)
        write_reg(REG_PERSP_PAIR, {scaled_q20(-(1 << 19), 1 << 19), scaled_q20(-(1 << 19), 1 << 19)});
      else
        write_reg(REG_PERSP_PAIR, {scaled_q20(-(1 << 17), 1 << 17), scaled_q20(-(1 << 17), 1 << 17)});
    end
    sz = $urandom_range(0, 9);
    write_reg(REG_SRC_WIDTH, sz == 0 ? $urandom_range(0, 8191) : $urandom_range(1, 4096));
    sz = $urandom_range(0, 9);
    write_reg(REG_SRC_HEIGHT, sz == 0 ? $urandom_range(0, 8191) : $urandom_range(1, 4096));
    write_reg(REG_SAMPLE_MODE, $urandom_range(0, 3));
  endtask

  initial begin
    warp_reg[REG_AFFINE_ROW0] = 64'd1048576;
    warp_reg[REG_OFFSET_X]    = '0;
    warp_reg[REG_AFFINE_ROW1] = 64'd4503599627370496;
    warp_reg[REG_OFFSET_Y]    = '0;
    warp_reg[REG_PERSP_PAIR]  = '0;
    warp_reg[REG_SRC_WIDTH]   = 64'd4096;
    warp_reg[REG_SRC_HEIGHT]  = 64'd4096;
    warp_reg[REG_SAMPLE_MODE] = 64'd1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset warp: identity, bilinear, bound size-1
    add_pixel(0, 0); add_pixel(4095, 4095); add_pixel(4094, 4094);
    add_pixel(4095, 0); add_pixel(0, 4095); add_pixel(1234, 2345);
    wait_drained();

    // nearest with half-pixel offsets: round half up, negative row goes outside
    write_reg(REG_SAMPLE_MODE, 2'b00);
    write_reg(REG_OFFSET_X, 32'h0000_0800);
    write_reg(REG_OFFSET_Y, 32'hffff_f800);
    add_pixel(0, 0); add_pixel(5, 5); add_pixel(4094, 10);
    wait_drained();

    // wide bound, nearest: 4095.6 rounds to the size and is clamped
    write_reg(REG_SAMPLE_MODE, 2'b10);
    write_reg(REG_OFFSET_X, 32'h0000_0999);
    write_reg(REG_OFFSET_Y, 32'h0);
    add_pixel(4095, 3); add_pixel(4094, 4095); add_pixel(4095, 4095);
    wait_drained();

    // oversize width saturates; zero height puts everything outside
    write_reg(REG_SAMPLE_MODE, 2'b11);
    write_reg(REG_SRC_WIDTH, 13'h1fff);
    write_reg(REG_SRC_HEIGHT, 13'd0);
    add_pixel(100, 100); add_pixel(4095, 0);
    wait_drained();
    write_reg(REG_SRC_WIDTH, 13'd1);
    write_reg(REG_SRC_HEIGHT, 13'd1);
    add_pixel(0, 0); add_pixel(1, 1);
    wait_drained();

    // w turns negative just past x = 1000; then coefficient extremes
    write_reg(REG_SRC_WIDTH, 13'd4096);
    write_reg(REG_SRC_HEIGHT, 13'd4096);
    write_reg(REG_PERSP_PAIR, {32'h0, 32'($signed(-(1 << 30) / 1000))});
    add_pixel(999, 0); add_pixel(1000, 0); add_pixel(4095, 0);
    wait_drained();
    write_reg(REG_AFFINE_ROW0, {32'h8000_0000, 32'h7fff_ffff});
    write_reg(REG_AFFINE_ROW1, {32'h7fff_ffff, 32'h8000_0000});
    write_reg(REG_PERSP_PAIR, {32'h7fff_ffff, 32'h8000_0000});
    write_reg(REG_OFFSET_X, 32'h7fff_ffff);
    write_reg(REG_OFFSET_Y, 32'h8000_0000);
    add_pixel(4095, 4095); add_pixel(0, 4095); add_pixel(4095, 0);
    wait_drained();

    // random warps; each phase drains completely before the next setup
    for (int ph = 0; ph < 20; ph++) begin
      random_setup($urandom_range(0, 3) == 0);
      quiet_sender = (ph % 4 == 1);
      for (int i = 0; i < 50; i++) add_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
      wait_drained();
    end

    repeat (LATENCY + 16) @(posedge clk_i);
    if (errors == 0 && sample_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
